/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the schedule unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BCS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bcs_pkg.sv */
// Types and constants of the beacon schedule unit.
package bcs_pkg;

   localparam int NumEntries = 2;
   localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;
   localparam int CntW       = $clog2(NumEntries + 1);
   localparam int IdW        = 4;
   localparam int SecW       = 32;
   localparam int BitCntW    = $clog2(SecW);
   localparam int ReqDataW   = 104;
   localparam int RspDataW   = 8;

   localparam logic [1:0] KIND_SET    = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_SELECT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIVIDE,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

/* hdl/beacon_config_schedule_unit.sv */
// Beacon profile schedule: entry table, tick walk with bit-serial remainder.
//
// channel  dir  tdata / tuser / tlast
// req_     in   tdata: entry_id, start_second, repeat_interval, now_second; tuser: kind
// rsp_     out  tdata: status, select_valid, selected_id; tlast: last of the item
//
// Set, select and unknown kinds, and a tick of an unchanged second, go from ST_IDLE straight
// to ST_FINISH, which registers the result. Any other tick checks each entry it walks in ST_WALK,
// and the end of the table when the walk is not cut short; for each periodic entry tested, its
// (now - start) mod interval runs through a restoring divider, 32 steps of one bit, and ST_EVAL
// then tests it. Reset empties every entry and clears the last second seen.
// A stalled rsp_ holds the walk only when a further result is due while one waits.
module beacon_config_schedule_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] entry_id, [39:8] start_second, [71:40] repeat_interval, [103:72] now_second
   input  logic [bcs_pkg::ReqDataW-1:0]  req_tdata,
   // [1:0] kind
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] status, [1] select_valid, [5:2] selected_id, [7:6] zero
   output logic [bcs_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);
   import bcs_pkg::*;

   `include "assert_macros.svh"

   state_type              state_ff, state_in;
   logic [CntW-1:0]        idx_ff, idx_in;
   logic [SecW-1:0]        now_ff, now_in;
   logic [SecW-1:0]        last_seen_ff, last_seen_in;
   logic [SecW-1:0]        start_ff [NumEntries];
   logic [SecW-1:0]        start_in [NumEntries];
   logic [SecW-1:0]        intv_ff [NumEntries];
   logic [SecW-1:0]        intv_in [NumEntries];
   logic                   pend_sel_ff, pend_sel_in;
   logic [IdW-1:0]         pend_id_ff, pend_id_in;
   logic                   pend_status_ff, pend_status_in;
   logic [SecW-1:0]        rem_ff, rem_in;
   logic [SecW-1:0]        dvd_ff, dvd_in;
   logic [SecW-1:0]        div_ff, div_in;
   logic [BitCntW-1:0]     bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]    rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [7:0]             req_id;
   logic [SecW-1:0]        req_start, req_intv, req_now;
   logic                   push_ok;
   logic [SecW-1:0]        cur_s, cur_v;
   logic [SecW:0]          rem_sh, rem_diff;
   logic [RspDataW-1:0]    pend_word;

   assign req_id    = req_tdata[7:0];
   assign req_start = req_tdata[39:8];
   assign req_intv  = req_tdata[71:40];
   assign req_now   = req_tdata[103:72];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign push_ok   = !rsp_valid_ff || rsp_tready;
   assign cur_s     = start_ff[idx_ff[IdxW-1:0]];
   assign cur_v     = intv_ff[idx_ff[IdxW-1:0]];
   assign rem_sh    = {rem_ff, dvd_ff[SecW-1]};
   assign rem_diff  = rem_sh - {1'b0, div_ff};
   assign pend_word = {2'b00, pend_id_ff, pend_sel_ff, pend_status_ff};

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      now_in         = now_ff;
      last_seen_in   = last_seen_ff;
      start_in       = start_ff;
      intv_in        = intv_ff;
      pend_sel_in    = pend_sel_ff;
      pend_id_in     = pend_id_ff;
      pend_status_in = pend_status_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      div_in         = div_ff;
      bit_cnt_in     = bit_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pend_sel_in    = 1'b0;
               pend_id_in     = '0;
               pend_status_in = 1'b0;
               state_in       = ST_FINISH;
               unique case (req_tuser)
                  KIND_SET: begin
                     if (req_id >= 8'(NumEntries)) begin
                        pend_status_in = 1'b1;
                     end else if (req_start == '0 && req_intv == '0) begin
                        start_in[req_id[IdxW-1:0]] = '0;
                        intv_in[req_id[IdxW-1:0]]  = '0;
                        pend_sel_in = 1'b1;
                        pend_id_in  = req_id[IdW-1:0];
                     end else begin
                        start_in[req_id[IdxW-1:0]] = req_start;
                        intv_in[req_id[IdxW-1:0]]  = req_intv;
                     end
                  end
                  KIND_TICK: begin
                     if (req_now != last_seen_ff) begin
                        last_seen_in = req_now;
                        now_in       = req_now;
                        idx_in       = '0;
                        state_in     = ST_WALK;
                     end
                  end
                  KIND_SELECT: begin
                     if (req_id >= 8'(NumEntries)) begin
                        pend_status_in = 1'b1;
                     end else begin
                        pend_sel_in = 1'b1;
                        pend_id_in  = req_id[IdW-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (idx_ff == CntW'(NumEntries)) begin
               state_in = ST_FINISH;
            end else if (now_ff < cur_s) begin
               idx_in = idx_ff + 1'b1;
            end else if (cur_v == '0) begin
               if (cur_s == '0) begin
                  state_in = ST_FINISH;
               end else if (!pend_sel_ff || push_ok) begin
                  // one-shot due: earlier pending selection goes out, not last
                  if (pend_sel_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_word;
                     rsp_last_in  = 1'b0;
                  end
                  pend_sel_in = 1'b1;
                  pend_id_in  = IdW'(idx_ff);
                  start_in[idx_ff[IdxW-1:0]] = '0;
                  intv_in[idx_ff[IdxW-1:0]]  = '0;
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               rem_in     = '0;
               dvd_in     = now_ff - cur_s;
               div_in     = cur_v;
               bit_cnt_in = BitCntW'(SecW - 1);
               state_in   = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            // restoring division, one quotient bit a cycle; only the remainder is kept
            rem_in     = rem_diff[SecW] ? rem_sh[SecW-1:0] : rem_diff[SecW-1:0];
            dvd_in     = {dvd_ff[SecW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (rem_ff != '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_WALK;
            end else if (!pend_sel_ff || push_ok) begin
               if (pend_sel_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_word;
                  rsp_last_in  = 1'b0;
               end
               pend_sel_in = 1'b1;
               pend_id_in  = IdW'(idx_ff);
               state_in    = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (push_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_word;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         last_seen_ff   <= '0;
         pend_sel_ff    <= 1'b0;
         pend_id_ff     <= '0;
         pend_status_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NumEntries; i++) begin
            start_ff[i] <= '0;
            intv_ff[i]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         last_seen_ff   <= last_seen_in;
         pend_sel_ff    <= pend_sel_in;
         pend_id_ff     <= pend_id_in;
         pend_status_ff <= pend_status_in;
         rsp_valid_ff   <= rsp_valid_in;
         start_ff       <= start_in;
         intv_ff        <= intv_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      div_ff      <= div_in;
      bit_cnt_ff  <= bit_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `BCS_ASSERT(a_div_done, clock, reset, (state_ff == ST_DIVIDE && bit_cnt_ff == '0) |=> (state_ff == ST_EVAL), "divider did not hand over after the last bit")
   `BCS_ASSERT(a_rem_below_div, clock, reset, (state_ff == ST_DIVIDE) |-> (rem_ff < div_ff), "partial remainder not below the interval")
   `BCS_ASSERT(a_pend_id_zero, clock, reset, !pend_sel_ff |-> (pend_id_ff == '0), "unselected word carries a profile id")
   `BCS_ASSERT(a_walk_bound, clock, reset, (state_ff == ST_WALK) |-> (idx_ff <= CntW'(NumEntries)), "walk index past the table")

endmodule

/* verif/beacon_config_schedule_unit_test.sv */
// Self-checking bench for the beacon schedule unit: predicts each selection and checks every word.
module beacon_config_schedule_unit_test;
   import bcs_pkg::*;

   localparam logic [1:0] KIND_UNUSED     = 2'd3;
   localparam bit         STATUS_OK       = 1'b0;
   localparam bit         STATUS_BAD_PARAM = 1'b1;

   typedef struct packed {
      bit           status;
      bit           select_valid;
      bit [IdW-1:0] selected_id;
      bit           last;
   } selection_word_type;

   // Tracks the schedule table and holds the words the unit still owes.
   class schedule_scoreboard_type;
      bit [SecW-1:0]      entry_start[NumEntries];
      bit [SecW-1:0]      entry_interval[NumEntries];
      bit [SecW-1:0]      last_second;
      bit [IdW-1:0]       active_profile;
      selection_word_type owed_words[$];
      int                 mismatches;

      function new();
         foreach (entry_start[i]) begin
            entry_start[i]    = '0;
            entry_interval[i] = '0;
         end
         last_second    = '0;
         active_profile = '0;
         mismatches     = 0;
      endfunction

      function void owe(bit status, bit sel, bit [IdW-1:0] id, bit last);
         selection_word_type w;
         w.status       = status;
         w.select_valid = sel;
         w.selected_id  = sel ? id : '0;
         w.last         = last;
         owed_words.push_back(w);
      endfunction

      function void note_request(bit [1:0] kind, bit [7:0] id, bit [SecW-1:0] start,
                                 bit [SecW-1:0] interval, bit [SecW-1:0] now);
         selection_word_type picks[$];
         selection_word_type w;
         bit [SecW-1:0]      s;
         bit [SecW-1:0]      v;
         int                 i;
         case (kind)
            KIND_SET: begin
               if (id >= NumEntries) begin
                  owe(STATUS_BAD_PARAM, 1'b0, '0, 1'b1);
               end else if (start == 0 && interval == 0) begin
                  entry_start[id]    = '0;
                  entry_interval[id] = '0;
                  active_profile     = id[IdW-1:0];
                  owe(STATUS_OK, 1'b1, active_profile, 1'b1);
               end else begin
                  entry_start[id]    = start;
                  entry_interval[id] = interval;
                  owe(STATUS_OK, 1'b0, '0, 1'b1);
               end
            end
            KIND_TICK: begin
               if (now != last_second) begin
                  last_second = now;
                  for (i = 0; i < NumEntries; i++) begin
                     s = entry_start[i];
                     v = entry_interval[i];
                     if (now < s) continue;
                     if (v == 0) begin
                        // start and interval both zero: empty slot ends the walk
                        if (s == 0) break;
                        active_profile    = i[IdW-1:0];
                        entry_start[i]    = '0;
                        entry_interval[i] = '0;
                        w = '{STATUS_OK, 1'b1, active_profile, 1'b0};
                        picks.push_back(w);
                     end else if (((now - s) % v) == 0) begin
                        active_profile = i[IdW-1:0];
                        w = '{STATUS_OK, 1'b1, active_profile, 1'b0};
                        picks.push_back(w);
                        break;
                     end
                  end
               end
               if (picks.size() == 0) begin
                  owe(STATUS_OK, 1'b0, '0, 1'b1);
               end else begin
                  picks[picks.size()-1].last = 1'b1;
                  foreach (picks[k]) owed_words.push_back(picks[k]);
               end
            end
            KIND_SELECT: begin
               if (id >= NumEntries) begin
                  owe(STATUS_BAD_PARAM, 1'b0, '0, 1'b1);
               end else begin
                  active_profile = id[IdW-1:0];
                  owe(STATUS_OK, 1'b1, active_profile, 1'b1);
               end
            end
            default: owe(STATUS_OK, 1'b0, '0, 1'b1);
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_response(logic [RspDataW-1:0] data, logic last);
         selection_word_type want;
         if (owed_words.size() == 0) begin
            report_mismatch($sformatf("word %h last %b arrived with nothing owed", data, last));
            return;
         end
         want = owed_words.pop_front();
         if (data[0] !== want.status)
            report_mismatch($sformatf("status %b, predicted %b", data[0], want.status));
         if (data[1] !== want.select_valid)
            report_mismatch($sformatf("select_valid %b, predicted %b", data[1],
                                      want.select_valid));
         if (data[5:2] !== want.selected_id)
            report_mismatch($sformatf("selected_id %0d, predicted %0d", data[5:2],
                                      want.selected_id));
         if (last !== want.last)
            report_mismatch($sformatf("tlast %b, predicted %b", last, want.last));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;

   schedule_scoreboard_type sched = new();
   int                      idle_odds = 0;   // 0: no idling, else 1 chance in idle_odds

   beacon_config_schedule_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Called just after a rising edge; returns after the edge that took the word and any idle.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] id,
                            input logic [SecW-1:0] start, input logic [SecW-1:0] interval,
                            input logic [SecW-1:0] now);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {now, interval, start, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sched.note_request(kind, id, start, interval, now);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // result side: check accepted words, stall in bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sched.check_response(rsp_tdata, rsp_tlast);
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) rsp_tready <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
         end
      end
   end

   initial begin
      int              n;
      int              r;
      logic [1:0]      kind;
      logic [7:0]      id;
      logic [SecW-1:0] start;
      logic [SecW-1:0] interval;
      logic [SecW-1:0] now;
      logic [SecW-1:0] cur_sec;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_SET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_odds = 4;

      // directed: edges of the fields and each branch of the walk
      send_item(KIND_TICK, 8'h00, '0, '0, '0);              // same second as reset
      send_item(KIND_UNUSED, 8'hff, '1, '1, '1);
      send_item(KIND_SET, 8'hff, '1, '1, '1);               // index out of range
      send_item(KIND_SET, 8'(NumEntries), 32'd1, 32'd1, '0); // first bad index
      send_item(KIND_SELECT, 8'hff, '0, '0, '0);
      send_item(KIND_SELECT, 8'd1, '0, '0, '0);
      send_item(KIND_SELECT, 8'd0, '0, '0, '0);
      send_item(KIND_SET, 8'd0, '0, '0, '1);                // clear selects
      send_item(KIND_SET, 8'd1, 32'd10, '0, '0);            // one-shot
      send_item(KIND_SET, 8'd0, 32'd5, '0, '0);
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd4);            // both still ahead
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd10);           // two one-shots fire
      send_item(KIND_SET, 8'd0, 32'd20, 32'd3, '0);
      send_item(KIND_SET, 8'd1, '0, 32'd1, '0);
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd21);           // entry 0 not due, 1 due
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd23);           // entry 0 due, walk stops
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd23);           // unchanged second
      send_item(KIND_SET, 8'd0, '1, '1, '0);
      send_item(KIND_TICK, 8'd0, '0, '0, '1);
      send_item(KIND_SET, 8'd0, '0, '0, '0);
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd5);            // empty slot ends walk
      send_item(KIND_SET, 8'd0, '0, 32'd7, '0);
      send_item(KIND_SET, 8'd1, '0, '1, '0);
      send_item(KIND_TICK, 8'd0, '0, '0, 32'd14);
      send_item(KIND_TICK, 8'd0, '0, '0, '0);               // wraps to second zero

      cur_sec = 32'd100;
      for (n = 0; n < 260; n++) begin
         if (n % 30 == 0) idle_odds = ($urandom_range(0, 2) != 0) ? 4 : 0;
         if (n >= 220) idle_odds = 0;
         start    = $urandom;
         interval = $urandom;
         now      = $urandom;
         id       = 8'($urandom_range(0, 255));
         r        = $urandom_range(0, 99);
         if (r < 30) begin
            kind = KIND_SET;
            if ($urandom_range(0, 9) != 0) id = 8'($urandom_range(0, NumEntries - 1));
            case ($urandom_range(0, 9))
               0: begin
                  start    = '0;
                  interval = '0;
               end
               1: ;                                  // full-range start and interval
               2, 3, 4: begin
                  start    = cur_sec + $urandom_range(0, 6) - 2;
                  interval = '0;
               end
               default: begin
                  start    = cur_sec + $urandom_range(0, 6) - 4;
                  interval = $urandom_range(1, 6);
               end
            endcase
         end else if (r < 80) begin
            kind = KIND_TICK;
            if ($urandom_range(0, 19) == 0) cur_sec = $urandom;
            else cur_sec = cur_sec + $urandom_range(0, 2);
            now = cur_sec;
         end else if (r < 93) begin
            kind = KIND_SELECT;
            if ($urandom_range(0, 5) != 0) id = 8'($urandom_range(0, NumEntries - 1));
         end else begin
            kind = 2'($urandom_range(0, 3));         // noise
         end
         send_item(kind, id, start, interval, now);
      end
      req_tvalid <= 1'b0;

      while (sched.owed_words.size() != 0) @(posedge clock);
      repeat (2 + 35 * NumEntries + 10) @(posedge clock);
      if (sched.mismatches == 0 && sched.owed_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/bcs_pkg.sv
hdl/beacon_config_schedule_unit.sv
verif/beacon_config_schedule_unit_test.sv
